// File: rtl/fftrk_pkg.sv
// Shared types, constants and helpers of the fragment fate tracker.
// Depends on nothing; imported by fragment_fate_tracker_unit.
package fftrk_pkg;

	localparam int PENDING_SLOTS = 256;
	localparam int OBJECT_TAGS   = 64;

	// Only slots and tags that the 8-bit and 6-bit fields can reach need storage.
	localparam int PEND_USED = (PENDING_SLOTS < 256) ? PENDING_SLOTS : 256;
	localparam int TAG_USED  = (OBJECT_TAGS < 64) ? OBJECT_TAGS : 64;
	localparam int PEND_AW   = $clog2(PEND_USED);
	localparam int TAG_AW    = $clog2(TAG_USED);

	// The clearing pass after reset covers the deeper of the two memories.
	localparam int CLEAR_LEN = (PEND_USED > TAG_USED) ? PEND_USED : TAG_USED;
	localparam int CLEAR_AW  = $clog2(CLEAR_LEN);

	localparam int SIZE_W   = 24;
	localparam int TOTAL_W  = 48;
	localparam int SLOT_W   = 8;
	localparam int TAG_W    = 6;
	localparam int MARGIN_W = 8;

	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd16;

	localparam logic [1:0] FATE_DELIVERED = 2'd0;
	localparam logic [1:0] FATE_EXPIRED   = 2'd1;

	localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
	localparam logic [1:0] VERDICT_MARKED = 2'd1;
	localparam logic [1:0] VERDICT_DROP   = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic [SIZE_W-1:0] original;
		logic [SIZE_W-1:0] accounted;
		logic              dropped;
		logic              congestion;
	} pend_entry_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] delivered;
		logic [TOTAL_W-1:0] expired;
		logic [TOTAL_W-1:0] dropped;
	} totals_t;

	// Reduce a slot number modulo the table depth: one conditional subtract per bit.
	function automatic logic [PEND_AW-1:0] slot_to_index(input logic [SLOT_W-1:0] slot);
		logic [19:0] v;
		logic [19:0] d;
		v = {12'd0, slot};
		for (int k = 7; k >= 0; k--) begin
			d = 20'(PEND_USED) << k;
			if (v >= d) begin
				v = v - d;
			end
		end
		return v[PEND_AW-1:0];
	endfunction

	// Add a fragment size to a 48-bit total, holding at full scale.
	function automatic logic [TOTAL_W-1:0] sat_add48(input logic [TOTAL_W-1:0] a,
	                                                 input logic [SIZE_W-1:0] b);
		logic [TOTAL_W:0] s;
		s = {1'b0, a} + {{(TOTAL_W+1-SIZE_W){1'b0}}, b};
		return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
	endfunction

endpackage

// File: rtl/fftrk_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module fftrk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/fragment_fate_tracker_unit.sv
// Fragment fate tracker: per-packet verdicts and per-object fate totals.
// Depends on fftrk_pkg and fftrk_ram.
//
// Usage:
//  - Input channel: drive the fragment fields and raise start; the transaction is
//    taken at a rising edge with start high and busy low.
//  - Each transaction returns exactly one result: done rises at the edge that ends the
//    update cycle and is high for one cycle. It carries slot_out, verdict_ready,
//    verdict_code and the tag's updated totals (all zero for tag 0). The receiver
//    cannot stall; capture it in that cycle.
//  - Flow: no new fragment is taken before the last is written back. The accepting
//    edge launches the RAM reads; the following cycle modifies the entries and writes
//    them back, with busy high. The next read therefore always sees the previous write.
//  - Configuration: cfg_data carries completion_margin; it is written when
//    cfg_valid and cfg_ready are high (cfg_ready is always high). Write it only
//    while no transaction is in flight.
//  - Reset (arst_n low): the margin returns to 16. After release a clearing pass
//    zeroes one address of each memory per cycle (totals only below TAG_USED),
//    with busy high until all CLEAR_LEN (256) addresses are done; then start is taken.
module fragment_fate_tracker_unit
	import fftrk_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                start,
	output logic                busy,
	input  logic [SLOT_W-1:0]   packet_slot,
	input  logic [SIZE_W-1:0]   fragment_bits,
	input  logic [SIZE_W-1:0]   original_bits,
	input  logic [1:0]          fate,
	input  logic                ce_flag,
	input  logic [TAG_W-1:0]    object_tag,

	output logic                done,
	output logic [SLOT_W-1:0]   slot_out,
	output logic                verdict_ready,
	output logic [1:0]          verdict_code,
	output logic [TOTAL_W-1:0]  object_delivered,
	output logic [TOTAL_W-1:0]  object_expired,
	output logic [TOTAL_W-1:0]  object_dropped,

	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [MARGIN_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic                accept;
	logic [PEND_AW-1:0]  pend_idx;
	logic [TAG_AW-1:0]   tag_idx;
	logic                tag_ok;

	// Clearing pass after reset: one address per cycle.
	logic [CLEAR_AW-1:0] clr_q;
	logic                clearing;
	logic                clr_pend_ok;
	logic                clr_tot_ok;

	logic [MARGIN_W-1:0] margin_q;

	// Transaction captured at the accepting edge.
	logic [SLOT_W-1:0]   slot_s1;
	logic [PEND_AW-1:0]  idx_s1;
	logic [SIZE_W-1:0]   frag_s1;
	logic [SIZE_W-1:0]   orig_s1;
	logic [1:0]          fate_s1;
	logic                ce_s1;
	logic                tag_ok_s1;
	logic [TAG_AW-1:0]   tag_idx_s1;

	pend_entry_t pend_rdata, pend_cur, pend_new, pend_wdata, pend_wdin;
	totals_t     tot_rdata, tot_cur, tot_new, tot_wdin;

	logic [PEND_AW-1:0] pend_waddr;
	logic [TAG_AW-1:0]  tot_waddr;

	logic              pend_we, tot_we;
	logic [SIZE_W:0]   acc_sum;
	logic [SIZE_W:0]   cmp_sum;
	logic              complete;
	logic [1:0]        code;

	// Result registers.
	logic               done_q;
	logic [SLOT_W-1:0]  slot_out_q;
	logic               ready_q;
	logic [1:0]         code_q;
	totals_t            tot_out_q;

	assign accept   = start && !busy;
	assign pend_idx = slot_to_index(packet_slot);
	assign tag_idx  = object_tag[TAG_AW-1:0];
	assign tag_ok   = (object_tag != '0) && ({26'd0, object_tag} < 32'(TAG_USED));

	assign clr_pend_ok = ({{(32-CLEAR_AW){1'b0}}, clr_q} < 32'(PEND_USED));
	assign clr_tot_ok  = ({{(32-CLEAR_AW){1'b0}}, clr_q} < 32'(TAG_USED));

	// ---------------------------------------------------------------- control FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		busy     = 1'b0;
		clearing = 1'b0;
		pend_we  = 1'b0;
		tot_we   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				busy     = 1'b1;
				clearing = 1'b1;
				pend_we  = clr_pend_ok;
				tot_we   = clr_tot_ok;
				if (clr_q == CLEAR_AW'(CLEAR_LEN - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				busy    = 1'b1;
				pend_we = 1'b1;
				tot_we  = tag_ok_s1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance the clearing address while the pass runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + CLEAR_AW'(1);
		end
	end

	// ---------------------------------------------------------------- configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			margin_q <= cfg_data;
		end
	end

	// ---------------------------------------------------------------- capture
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_s1    <= packet_slot;
			idx_s1     <= pend_idx;
			frag_s1    <= fragment_bits;
			orig_s1    <= original_bits;
			fate_s1    <= fate;
			ce_s1      <= ce_flag;
			tag_ok_s1  <= tag_ok;
			tag_idx_s1 <= tag_idx;
		end
	end

	// ---------------------------------------------------------------- state memories
	assign pend_waddr = clearing ? clr_q[PEND_AW-1:0] : idx_s1;
	assign pend_wdin  = clearing ? '0 : pend_wdata;
	assign tot_waddr  = clearing ? clr_q[TAG_AW-1:0] : tag_idx_s1;
	assign tot_wdin   = clearing ? '0 : tot_new;

	fftrk_ram #(
		.WIDTH($bits(pend_entry_t)),
		.DEPTH(PEND_USED)
	) u_pend_ram (
		.clk  (clk),
		.we   (pend_we),
		.waddr(pend_waddr),
		.wdata(pend_wdin),
		.raddr(pend_idx),
		.rdata(pend_rdata)
	);

	fftrk_ram #(
		.WIDTH($bits(totals_t)),
		.DEPTH(TAG_USED)
	) u_tot_ram (
		.clk  (clk),
		.we   (tot_we),
		.waddr(tot_waddr),
		.wdata(tot_wdin),
		.raddr(tag_idx),
		.rdata(tot_rdata)
	);

	// ---------------------------------------------------------------- modify
	always_comb begin
		pend_cur = pend_rdata;

		pend_new.original   = (pend_cur.original == '0) ? orig_s1 : pend_cur.original;
		acc_sum             = {1'b0, pend_cur.accounted} + {1'b0, frag_s1};
		// Saturate the accounted bits at full scale.
		pend_new.accounted  = acc_sum[SIZE_W] ? {SIZE_W{1'b1}} : acc_sum[SIZE_W-1:0];
		pend_new.dropped    = pend_cur.dropped || (fate_s1 != FATE_DELIVERED);
		pend_new.congestion = pend_cur.congestion || ce_s1;

		cmp_sum  = {1'b0, pend_new.accounted} + {{(SIZE_W+1-MARGIN_W){1'b0}}, margin_q};
		complete = (pend_new.original != '0) && (cmp_sum >= {1'b0, pend_new.original});

		if (pend_new.dropped) begin
			code = VERDICT_DROP;
		end else if (pend_new.congestion) begin
			code = VERDICT_MARKED;
		end else begin
			code = VERDICT_ACCEPT;
		end

		// Drop a completed entry back to empty.
		pend_wdata = complete ? '0 : pend_new;
	end

	always_comb begin
		tot_cur = tot_rdata;
		tot_new = tot_cur;
		case (fate_s1)
			FATE_DELIVERED: tot_new.delivered = sat_add48(tot_cur.delivered, frag_s1);
			FATE_EXPIRED:   tot_new.expired   = sat_add48(tot_cur.expired, frag_s1);
			default:        tot_new.dropped   = sat_add48(tot_cur.dropped, frag_s1);
		endcase
	end

	// ---------------------------------------------------------------- result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_UPDATE);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) begin
			slot_out_q <= slot_s1;
			ready_q    <= complete;
			code_q     <= complete ? code : VERDICT_ACCEPT;
			tot_out_q  <= tag_ok_s1 ? tot_new : '0;
		end
	end

	assign done             = done_q;
	assign slot_out         = slot_out_q;
	assign verdict_ready    = ready_q;
	assign verdict_code     = code_q;
	assign object_delivered = tot_out_q.delivered;
	assign object_expired   = tot_out_q.expired;
	assign object_dropped   = tot_out_q.dropped;

	// ---------------------------------------------------------------- assertions
	a_done_follows_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_UPDATE))
		else $error("result strobe without an update cycle");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not start an update");

	a_single_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |=> (!busy && done))
		else $error("update did not finish in one cycle");

	a_code_needs_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !verdict_ready) |-> (verdict_code == VERDICT_ACCEPT))
		else $error("verdict code set without a verdict");

	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!pend_we && !tot_we))
		else $error("memory write outside the update cycle");

endmodule
